@@ rtl/assert_macros.svh @@
// Concurrent assertion helpers, clocked on aclk, masked during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define CBA_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

`endif

@@ rtl/cba_pkg.sv @@
`timescale 1ns / 1ps

package cba_pkg;

    localparam int NUM_BLOCKS_DEF       = 8;
    localparam int BLOCK_PAYLOAD_DEF    = 423;
    localparam int RECORDS_PER_META_DEF = 3;

    localparam int LEN_W   = 16;
    localparam int BLK_W   = 10;
    localparam int LINK_W  = 11;
    localparam int SLOT_OW = 2;

    localparam logic signed [LINK_W-1:0] END_LINK = -11'sd1;

    typedef enum logic [2:0] {
        ST_DATA    = 3'd0,
        ST_META    = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_ZERO    = 3'd3,
        ST_NOMETA  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CAP,
        S_DECIDE,
        S_SCAN,
        S_TAIL,
        S_META
    } state_t;

endpackage

@@ rtl/chained_block_allocator.sv @@
`timescale 1ns / 1ps
// Channel  Ports                                   Direction  Carries
// s_       s_valid s_ready s_file_length           in         one request word
// m_       m_valid m_ready m_status m_block_index  out        one result word per
//          m_next_link m_record_slot m_start_block            block, then a record
//          m_last_result                                      (one word if rejected)
//
// The free map scan reads one used flag per cycle, unless a stalled m_ channel
// holds it, while the flag read before it is set if that block is picked.
// After reset a clearing pass initialises the used-flag memory, marking only
// block 0 as used; s_ready stays low throughout.
// A stalled m_ channel holds the scan; one result word is buffered in the output
// register, so s_ready returns while the last word waits.

`include "assert_macros.svh"

module chained_block_allocator
    import cba_pkg::*;
#(
    parameter int NUM_BLOCKS       = NUM_BLOCKS_DEF,
    parameter int BLOCK_PAYLOAD    = BLOCK_PAYLOAD_DEF,
    parameter int RECORDS_PER_META = RECORDS_PER_META_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [LEN_W-1:0]         s_file_length,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_status,
    output logic [BLK_W-1:0]         m_block_index,
    output logic signed [LINK_W-1:0] m_next_link,
    output logic [SLOT_OW-1:0]       m_record_slot,
    output logic [BLK_W-1:0]         m_start_block,
    output logic                     m_last_result
);

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int PAY_W  = $clog2(BLOCK_PAYLOAD + 1);
    localparam int CAP_W  = CNT_W + PAY_W;
    localparam int CMP_W  = (CAP_W > LEN_W) ? CAP_W : LEN_W;
    localparam int SLOT_W = (RECORDS_PER_META > 1) ? $clog2(RECORDS_PER_META) : 1;

    localparam logic [CNT_W-1:0]  NB_C      = CNT_W'(NUM_BLOCKS);
    localparam logic [LEN_W-1:0]  PAYLOAD_C = LEN_W'(BLOCK_PAYLOAD);
    localparam logic [PAY_W-1:0]  PAYLOAD_P = PAY_W'(BLOCK_PAYLOAD);
    localparam logic [SLOT_W-1:0] SLOT_MAX  = SLOT_W'(RECORDS_PER_META - 1);

    // used-flag memory
    logic used_mem [NUM_BLOCKS];
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_data_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            used_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= used_mem[rd_addr];
        end
    end

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              d_vld_reg, d_vld_next;
    logic [IDX_W-1:0]  d_idx_reg, d_idx_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]  start_reg, start_next;
    logic              nm_found_reg, nm_found_next;
    logic [IDX_W-1:0]  nm_reg, nm_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [CNT_W-1:0]  blocks_used_reg, blocks_used_next;
    logic              fc_nz_reg, fc_nz_next;
    logic [SLOT_W-1:0] fc_mod_reg, fc_mod_next;
    logic [IDX_W-1:0]  meta_tail_reg, meta_tail_next;

    logic                     m_valid_reg, m_valid_next;
    logic [2:0]               m_status_reg, m_status_next;
    logic [BLK_W-1:0]         m_blk_reg, m_blk_next;
    logic signed [LINK_W-1:0] m_link_reg, m_link_next;
    logic [SLOT_OW-1:0]       m_slot_reg, m_slot_next;
    logic [BLK_W-1:0]         m_start_reg, m_start_next;
    logic                     m_last_reg, m_last_next;

    logic out_free;
    logic emit;
    logic meta_due;
    logic pick;
    logic stall;
    logic issue;

    assign out_free = !m_valid_reg || m_ready;
    assign meta_due = fc_nz_reg && (fc_mod_reg == '0);
    assign issue    = rd_idx_reg < NB_C;
    assign pick     = d_vld_reg && !rd_data_reg && (rem_reg != '0);
    assign stall    = pick && pend_vld_reg && !out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            rd_idx_reg      <= '0;
            d_vld_reg       <= 1'b0;
            pend_vld_reg    <= 1'b0;
            nm_found_reg    <= 1'b0;
            blocks_used_reg <= CNT_W'(1);
            fc_nz_reg       <= 1'b0;
            fc_mod_reg      <= '0;
            meta_tail_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            rd_idx_reg      <= rd_idx_next;
            d_vld_reg       <= d_vld_next;
            pend_vld_reg    <= pend_vld_next;
            nm_found_reg    <= nm_found_next;
            blocks_used_reg <= blocks_used_next;
            fc_nz_reg       <= fc_nz_next;
            fc_mod_reg      <= fc_mod_next;
            meta_tail_reg   <= meta_tail_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_idx_reg    <= d_idx_next;
        pend_idx_reg <= pend_idx_next;
        start_reg    <= start_next;
        nm_reg       <= nm_next;
        len_reg      <= len_next;
        rem_reg      <= rem_next;
        cap_reg      <= cap_next;
        m_status_reg <= m_status_next;
        m_blk_reg    <= m_blk_next;
        m_link_reg   <= m_link_next;
        m_slot_reg   <= m_slot_next;
        m_start_reg  <= m_start_next;
        m_last_reg   <= m_last_next;
    end

    always_comb begin
        state_next       = state_reg;
        rd_idx_next      = rd_idx_reg;
        d_vld_next       = d_vld_reg;
        d_idx_next       = d_idx_reg;
        pend_vld_next    = pend_vld_reg;
        pend_idx_next    = pend_idx_reg;
        start_next       = start_reg;
        nm_found_next    = nm_found_reg;
        nm_next          = nm_reg;
        len_next         = len_reg;
        rem_next         = rem_reg;
        cap_next         = cap_reg;
        blocks_used_next = blocks_used_reg;
        fc_nz_next       = fc_nz_reg;
        fc_mod_next      = fc_mod_reg;
        meta_tail_next   = meta_tail_reg;

        rd_en   = 1'b0;
        rd_addr = rd_idx_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = rd_idx_reg[IDX_W-1:0];
        wr_data = 1'b0;

        emit          = 1'b0;
        m_status_next = m_status_reg;
        m_blk_next    = m_blk_reg;
        m_link_next   = m_link_reg;
        m_slot_next   = m_slot_reg;
        m_start_next  = m_start_reg;
        m_last_next   = m_last_reg;

        s_ready = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                wr_en       = 1'b1;
                wr_data     = (rd_idx_reg == '0);
                rd_idx_next = rd_idx_reg + CNT_W'(1);
                if (rd_idx_reg == NB_C - CNT_W'(1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    len_next   = s_file_length;
                    state_next = S_CAP;
                end
            end
            S_CAP: begin
                cap_next   = CAP_W'((NB_C - blocks_used_reg) * PAYLOAD_P);
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (out_free) begin
                    if (len_reg == '0) begin
                        emit          = 1'b1;
                        m_status_next = ST_ZERO;
                        state_next    = S_IDLE;
                    end else if (CMP_W'(len_reg) > CMP_W'(cap_reg)) begin
                        emit          = 1'b1;
                        m_status_next = ST_NOSPACE;
                        state_next    = S_IDLE;
                    end else begin
                        rem_next      = len_reg;
                        rd_idx_next   = '0;
                        d_vld_next    = 1'b0;
                        pend_vld_next = 1'b0;
                        nm_found_next = 1'b0;
                        state_next    = S_SCAN;
                    end
                    m_blk_next   = '0;
                    m_link_next  = END_LINK;
                    m_slot_next  = '0;
                    m_start_next = '0;
                    m_last_next  = 1'b1;
                end
            end
            S_SCAN: begin
                if (!stall) begin
                    if (pick) begin
                        wr_en            = 1'b1;
                        wr_addr          = d_idx_reg;
                        wr_data          = 1'b1;
                        blocks_used_next = blocks_used_reg + CNT_W'(1);
                        rem_next         = (rem_reg > PAYLOAD_C) ? rem_reg - PAYLOAD_C : '0;
                        pend_vld_next    = 1'b1;
                        pend_idx_next    = d_idx_reg;
                        if (pend_vld_reg) begin
                            emit          = 1'b1;
                            m_status_next = ST_DATA;
                            m_blk_next    = BLK_W'(pend_idx_reg);
                            m_link_next   = LINK_W'(d_idx_reg);
                            m_slot_next   = '0;
                            m_start_next  = BLK_W'(start_reg);
                            m_last_next   = 1'b0;
                        end else begin
                            start_next = d_idx_reg;
                        end
                    end else if (d_vld_reg && !rd_data_reg && (d_idx_reg != '0)) begin
                        nm_found_next = 1'b1;
                        nm_next       = d_idx_reg;
                    end
                    rd_en      = issue;
                    d_vld_next = issue;
                    d_idx_next = rd_idx_reg[IDX_W-1:0];
                    if (issue) begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end else begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                if (out_free) begin
                    emit          = 1'b1;
                    m_status_next = ST_DATA;
                    m_blk_next    = BLK_W'(pend_idx_reg);
                    m_link_next   = END_LINK;
                    m_slot_next   = '0;
                    m_start_next  = BLK_W'(start_reg);
                    m_last_next   = 1'b0;
                    state_next    = S_META;
                end
            end
            S_META: begin
                if (out_free) begin
                    emit         = 1'b1;
                    m_link_next  = END_LINK;
                    m_start_next = BLK_W'(start_reg);
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                    if (meta_due && !nm_found_reg) begin
                        m_status_next = ST_NOMETA;
                        m_blk_next    = '0;
                        m_slot_next   = '0;
                    end else begin
                        m_status_next = ST_META;
                        fc_nz_next    = 1'b1;
                        fc_mod_next   = (fc_mod_reg == SLOT_MAX) ? '0
                                                                 : fc_mod_reg + SLOT_W'(1);
                        if (meta_due) begin
                            wr_en            = 1'b1;
                            wr_addr          = nm_reg;
                            wr_data          = 1'b1;
                            blocks_used_next = blocks_used_reg + CNT_W'(1);
                            meta_tail_next   = nm_reg;
                            m_blk_next       = BLK_W'(nm_reg);
                            m_slot_next      = '0;
                        end else begin
                            m_blk_next  = BLK_W'(meta_tail_reg);
                            m_slot_next = SLOT_OW'(fc_mod_reg);
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_block_index = m_blk_reg;
    assign m_next_link   = m_link_reg;
    assign m_record_slot = m_slot_reg;
    assign m_start_block = m_start_reg;
    assign m_last_result = m_last_reg;

    `CBA_ASSERT(a_used_bound, blocks_used_reg <= NB_C, "block count above capacity")
    `CBA_ASSERT_IMPL(a_other_last, m_valid && m_status != ST_DATA, m_last_result,
                     "non-data word without last flag")
    `CBA_ASSERT_IMPL(a_data_not_last, m_valid && m_status == ST_DATA, !m_last_result,
                     "data word carries last flag")
    `CBA_ASSERT_IMPL(a_busy_after_req, s_valid && s_ready, ##1 !s_ready,
                     "request taken while previous one in flight")

endmodule
